/* rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

/* rtl/csbc_pkg.sv */
// shared constants and types for the clip space box cull block
package csbc_pkg;

    localparam int CORNERS    = 8;
    localparam int CNT_W      = 3;
    localparam int ENTRY_W    = 16;
    localparam int ROW_W      = 64;
    localparam int ONE_SHIFT  = 6;
    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X = 2'd0,
        CFG_ROW_Y = 2'd1,
        CFG_ROW_Z = 2'd2,
        CFG_ROW_W = 2'd3
    } t_cfg_idx;

    // plane bit positions in the mask
    localparam int PL_POS_X = 0;
    localparam int PL_NEG_X = 1;
    localparam int PL_POS_Y = 2;
    localparam int PL_NEG_Y = 3;
    localparam int PL_POS_Z = 4;
    localparam int PL_NEG_Z = 5;

endpackage

/* rtl/csbc_row_dot.sv */
// one matrix row times (x, y, z, 1): registered products, then registered sum
module csbc_row_dot #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    input  logic [csbc_pkg::ROW_W-1:0]    i_row,
    output logic signed [COORD_WIDTH+17:0] o_clip
);
    import csbc_pkg::*;

    localparam int PROD_W = COORD_WIDTH + ENTRY_W;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [ENTRY_W-1:0] e0, e1, e2, e3;
    logic signed [PROD_W-1:0]  n_prod [4];
    logic signed [PROD_W-1:0]  r_prod [4];
    logic signed [SUM_W-1:0]   n_clip;
    logic signed [SUM_W-1:0]   r_clip;

    assign e0 = signed'(i_row[ENTRY_W-1:0]);
    assign e1 = signed'(i_row[2*ENTRY_W-1:ENTRY_W]);
    assign e2 = signed'(i_row[3*ENTRY_W-1:2*ENTRY_W]);
    assign e3 = signed'(i_row[4*ENTRY_W-1:3*ENTRY_W]);

    always_comb begin
        n_prod[0] = PROD_W'(i_x) * PROD_W'(e0);
        n_prod[1] = PROD_W'(i_y) * PROD_W'(e1);
        n_prod[2] = PROD_W'(i_z) * PROD_W'(e2);
        // constant one is 1.0 in q10.6, so a shift
        n_prod[3] = signed'({{(COORD_WIDTH-ONE_SHIFT){e3[ENTRY_W-1]}}, e3,
                             {ONE_SHIFT{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign n_clip = SUM_W'(r_prod[0]) + SUM_W'(r_prod[1])
                  + SUM_W'(r_prod[2]) + SUM_W'(r_prod[3]);

    always_ff @(posedge i_clk) begin
        r_clip <= n_clip;
    end

    assign o_clip = r_clip;

endmodule

/* rtl/clip_space_box_cull.sv */
// top level: frustum cull of a bounding box, one corner per beat
// a box's eighth corner passes the input, product, clip sum and result registers before its result strobe
// throughput: one corner per cycle, busy stays low, set by the four-stage pipeline
// stages: input register, sixteen product registers, clip sums, plane flags and result
// reset (synchronous, active low): matrix rows to zero, flags to all ones,
// corner count to zero, pipeline empty
module clip_space_box_cull #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_x,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_y,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_z,
    input  logic                               i_cfg_we,
    input  logic [csbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csbc_pkg::ROW_W-1:0]         i_cfg_data,
    output logic                               o_result_valid,
    output logic                               o_visible,
    output logic [csbc_pkg::NUM_PLANES-1:0]    o_plane_mask
);
    import csbc_pkg::*;
    `include "assert_macros.svh"

    localparam int SUM_W = COORD_WIDTH + ENTRY_W + 2;
    localparam int CMP_W = SUM_W + 1;

    // matrix rows
    logic [ROW_W-1:0] r_row_x, r_row_y, r_row_z, r_row_w;

    // pipeline valid bits
    logic r_s1_valid, r_s2_valid, r_s3_valid;

    // stage 1 corner register
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;

    // stage 3 clip coordinates
    logic signed [SUM_W-1:0] cx, cy, cz, cw;

    // box accumulation
    logic [NUM_PLANES-1:0] r_plane_all, n_plane_all;
    logic [CNT_W-1:0]      r_corner_cnt, n_corner_cnt;
    logic [NUM_PLANES-1:0] out_now;
    logic [NUM_PLANES-1:0] all_now;
    logic                  last_corner;

    // result register
    logic                  r_res_valid, n_res_valid;
    logic                  r_visible, n_visible;
    logic [NUM_PLANES-1:0] r_mask, n_mask;

    // one beat per cycle, never held off
    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= '0;
            r_row_y <= '0;
            r_row_z <= '0;
            r_row_w <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X: r_row_x <= i_cfg_data;
                CFG_ROW_Y: r_row_y <= i_cfg_data;
                CFG_ROW_Z: r_row_z <= i_cfg_data;
                CFG_ROW_W: r_row_w <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // corner capture, payload only
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_x <= i_corner_x;
            r_y <= i_corner_y;
            r_z <= i_corner_z;
        end
    end

    // four row units: products in stage 2, clip sums in stage 3
    csbc_row_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_x (
        .i_clk(i_clk), .i_x(r_x), .i_y(r_y), .i_z(r_z), .i_row(r_row_x), .o_clip(cx)
    );
    csbc_row_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_y (
        .i_clk(i_clk), .i_x(r_x), .i_y(r_y), .i_z(r_z), .i_row(r_row_y), .o_clip(cy)
    );
    csbc_row_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_z (
        .i_clk(i_clk), .i_x(r_x), .i_y(r_y), .i_z(r_z), .i_row(r_row_z), .o_clip(cz)
    );
    csbc_row_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_w (
        .i_clk(i_clk), .i_x(r_x), .i_y(r_y), .i_z(r_z), .i_row(r_row_w), .o_clip(cw)
    );

    // plane tests, strict: a corner on a plane counts as inside
    // c < -w is tested as c + w < 0 one bit wider so it cannot wrap
    always_comb begin
        logic signed [CMP_W-1:0] sx, sy, sz;
        sx = CMP_W'(cx) + CMP_W'(cw);
        sy = CMP_W'(cy) + CMP_W'(cw);
        sz = CMP_W'(cz) + CMP_W'(cw);
        out_now           = '0;
        out_now[PL_POS_X] = cx > cw;
        out_now[PL_NEG_X] = sx[CMP_W-1];
        out_now[PL_POS_Y] = cy > cw;
        out_now[PL_NEG_Y] = sy[CMP_W-1];
        out_now[PL_POS_Z] = cz > cw;
        out_now[PL_NEG_Z] = sz[CMP_W-1];
    end

    assign all_now     = r_plane_all & out_now;
    assign last_corner = (r_corner_cnt == CNT_W'(CORNERS - 1));

    // flag and count update, result on the last corner of a box
    always_comb begin
        n_plane_all  = r_plane_all;
        n_corner_cnt = r_corner_cnt;
        n_res_valid  = 1'b0;
        n_visible    = r_visible;
        n_mask       = r_mask;
        if (r_s3_valid) begin
            if (last_corner) begin
                n_res_valid  = 1'b1;
                n_visible    = (all_now == '0);
                n_mask       = all_now;
                n_plane_all  = '1;
                n_corner_cnt = '0;
            end else begin
                n_plane_all  = all_now;
                n_corner_cnt = r_corner_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_all  <= '1;
            r_corner_cnt <= '0;
            r_res_valid  <= 1'b0;
        end else begin
            r_plane_all  <= n_plane_all;
            r_corner_cnt <= n_corner_cnt;
            r_res_valid  <= n_res_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_visible <= n_visible;
        r_mask    <= n_mask;
    end

    assign o_result_valid = r_res_valid;
    assign o_visible      = r_visible;
    assign o_plane_mask   = r_mask;

    // visible bit agrees with the mask on every result beat
    `ASSERT_CLK(a_vis_mask, i_clk, i_rst_n,
        o_result_valid |-> (o_visible == (o_plane_mask == '0)), "visible disagrees with mask")
    // a result follows only a last corner leaving stage 3
    `ASSERT_CLK(a_res_src, i_clk, i_rst_n,
        o_result_valid |-> ($past(r_s3_valid) && ($past(r_corner_cnt) == CNT_W'(CORNERS - 1))),
        "result without a last corner")
    // two results never arrive back to back, a box has several corners
    `ASSERT_CLK(a_res_gap, i_clk, i_rst_n,
        o_result_valid |=> !o_result_valid, "results on consecutive cycles")
    // corner count holds while no corner leaves stage 3
    `ASSERT_CLK(a_cnt_hold, i_clk, i_rst_n,
        !r_s3_valid |=> $stable(r_corner_cnt), "corner count moved without a corner")
    // flags are all ones whenever a box is just starting
    `ASSERT_NEVER(a_flags_fresh, i_clk, i_rst_n,
        (r_corner_cnt == '0) && (r_plane_all != '1), "flags not reset at box start")

endmodule

/* sim/csbc_checker.sv */
// checker for the clip space box cull block: predicts each box verdict and compares
module csbc_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_x,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_y,
    input  logic signed [COORD_WIDTH-1:0]      i_corner_z,
    input  logic                               i_cfg_we,
    input  logic [csbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [csbc_pkg::ROW_W-1:0]         i_cfg_data,
    input  logic                               i_result_valid,
    input  logic                               i_visible,
    input  logic [csbc_pkg::NUM_PLANES-1:0]    i_plane_mask,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_boxes_checked,
    output int                                 o_boxes_culled
);
    import csbc_pkg::*;

    localparam int PRINT_CAP = 30;

    typedef struct packed {
        logic                  visible;
        logic [NUM_PLANES-1:0] mask;
    } t_box_verdict;

    t_box_verdict          box_verdicts_q[$];
    logic [ROW_W-1:0]      row_x, row_y, row_z, row_w;
    logic [NUM_PLANES-1:0] still_outside;
    int unsigned           corners_in_box;
    int                    errors;
    int                    printed;
    int                    checked;
    int                    culled;

    // one clip coordinate: three products plus the row's constant term times 1.0
    function automatic longint clip_dot(input logic [ROW_W-1:0] row,
                                        input longint x, input longint y, input longint z);
        longint ex, ey, ez, e1;
        ex = longint'($signed(row[0*ENTRY_W +: ENTRY_W]));
        ey = longint'($signed(row[1*ENTRY_W +: ENTRY_W]));
        ez = longint'($signed(row[2*ENTRY_W +: ENTRY_W]));
        e1 = longint'($signed(row[3*ENTRY_W +: ENTRY_W]));
        return ex * x + ey * y + ez * z + e1 * (longint'(1) <<< ONE_SHIFT);
    endfunction

    // planes this corner lies strictly beyond
    function automatic logic [NUM_PLANES-1:0] planes_beyond(input longint cx, input longint cy,
                                                           input longint cz, input longint cw);
        logic [NUM_PLANES-1:0] m;
        m           = '0;
        m[PL_POS_X] = cx > cw;
        m[PL_NEG_X] = cx < -cw;
        m[PL_POS_Y] = cy > cw;
        m[PL_NEG_Y] = cy < -cw;
        m[PL_POS_Z] = cz > cw;
        m[PL_NEG_Z] = cz < -cw;
        return m;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        errors++;
        if (printed < PRINT_CAP) begin
            printed++;
            $display("csbc_checker: %s mismatch, expected %0h got %0h", what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_box_verdict          want;
        longint                x, y, z;
        logic [NUM_PLANES-1:0] out_now;
        if (!i_rst_n) begin
            row_x          = '0;
            row_y          = '0;
            row_z          = '0;
            row_w          = '0;
            still_outside  = '1;
            corners_in_box = 0;
            box_verdicts_q.delete();
        end else begin
            // result strobe first: it always belongs to a box closed earlier
            if (i_result_valid) begin
                if (box_verdicts_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, {i_visible, i_plane_mask});
                end else begin
                    want = box_verdicts_q.pop_front();
                    checked++;
                    if (!want.visible)
                        culled++;
                    if (i_visible !== want.visible)
                        report_mismatch("visible", want.visible, i_visible);
                    if (i_plane_mask !== want.mask)
                        report_mismatch("plane mask", want.mask, i_plane_mask);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROW_X: row_x = i_cfg_data;
                    CFG_ROW_Y: row_y = i_cfg_data;
                    CFG_ROW_Z: row_z = i_cfg_data;
                    CFG_ROW_W: row_w = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                x       = longint'(i_corner_x);
                y       = longint'(i_corner_y);
                z       = longint'(i_corner_z);
                out_now = planes_beyond(clip_dot(row_x, x, y, z), clip_dot(row_y, x, y, z),
                                        clip_dot(row_z, x, y, z), clip_dot(row_w, x, y, z));
                still_outside = still_outside & out_now;
                if (corners_in_box == CORNERS - 1) begin
                    want.visible = (still_outside == '0);
                    want.mask    = still_outside;
                    box_verdicts_q.insert(box_verdicts_q.size(), want);
                    still_outside  = '1;
                    corners_in_box = 0;
                end else begin
                    corners_in_box++;
                end
            end
        end
        o_pending       <= box_verdicts_q.size();
        o_fail_count    <= errors;
        o_boxes_checked <= checked;
        o_boxes_culled  <= culled;
    end

endmodule

/* sim/tb_top.sv */
// testbench top for the clip space box cull block: stimulus, watchdog and verdict
module tb_top;
    import csbc_pkg::*;

    localparam int CW              = 16;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 8;     // drain wait after the verdicts; the pipeline is four deep
    localparam int STALL_LIMIT     = 4000;  // cycles with no beat and no result
    localparam int RAND_PHASES     = 10;
    localparam int BOXES_PER_PHASE = 13;

    // matrix flavors used by the random phases
    typedef enum int {
        MX_PERSPECTIVE,
        MX_RANDOM,
        MX_ALL_MAX,
        MX_ALL_MIN,
        MX_ZERO,
        MX_MIRRORED
    } t_matrix_kind;

    localparam t_matrix_kind PHASE_KIND [RAND_PHASES] = '{
        MX_PERSPECTIVE, MX_RANDOM, MX_ALL_MAX, MX_ALL_MIN, MX_PERSPECTIVE,
        MX_RANDOM, MX_ZERO, MX_MIRRORED, MX_PERSPECTIVE, MX_RANDOM
    };

    // sender idle percentage per phase, rotating: none, heavy, none, light
    // (the result side has no stall, so its phase runs with the sender steady)
    localparam int IDLE_PCT [4] = '{0, 79, 0, 7};

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   start       = 1'b0;
    logic signed [CW-1:0]   i_corner_x  = '0;
    logic signed [CW-1:0]   i_corner_y  = '0;
    logic signed [CW-1:0]   i_corner_z  = '0;
    logic                   i_cfg_we    = 1'b0;
    t_cfg_idx               i_cfg_idx   = CFG_ROW_X;
    logic [ROW_W-1:0]       i_cfg_data  = '0;

    logic                   busy;
    logic                   o_result_valid;
    logic                   o_visible;
    logic [NUM_PLANES-1:0]  o_plane_mask;

    int fail_count;
    int pending;
    int boxes_checked;
    int boxes_culled;
    int idle_pct         = 0;
    int corners_sent     = 0;
    int matrices_loaded  = 0;
    int quiet_cycles     = 0;

    clip_space_box_cull #(
        .COORD_WIDTH   (CW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_corner_x     (i_corner_x),
        .i_corner_y     (i_corner_y),
        .i_corner_z     (i_corner_z),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_visible      (o_visible),
        .o_plane_mask   (o_plane_mask)
    );

    csbc_checker #(
        .COORD_WIDTH   (CW)
    ) cull_watch (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_corner_x      (i_corner_x),
        .i_corner_y      (i_corner_y),
        .i_corner_z      (i_corner_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_result_valid  (o_result_valid),
        .i_visible       (o_visible),
        .i_plane_mask    (o_plane_mask),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_boxes_checked (boxes_checked),
        .o_boxes_culled  (boxes_culled)
    );

    // 10 unit clock period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: any corner beat or result strobe counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("tb_top: no progress for %0d cycles", STALL_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // four Q3.12 entries into one row: x, y, z, then the constant term on top
    function automatic logic [ROW_W-1:0] pack_row(input logic [ENTRY_W-1:0] ex,
                                                  input logic [ENTRY_W-1:0] ey,
                                                  input logic [ENTRY_W-1:0] ez,
                                                  input logic [ENTRY_W-1:0] e1);
        return {e1, ez, ey, ex};
    endfunction

    // random sender gaps, start held low while idle
    task automatic sender_gap();
        while (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // one corner beat; start stays high afterward so back-to-back beats need no toggle
    task automatic send_corner(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z);
        sender_gap();
        start      <= 1'b1;
        i_corner_x <= x;
        i_corner_y <= y;
        i_corner_z <= z;
        do
            @(posedge i_clk);
        while (busy);
        corners_sent++;
    endtask

    // drop start, wait for every box verdict, then let the pipeline empty
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_row(input t_cfg_idx idx, input logic [ROW_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // only called with the block idle; write enable drops once after all four rows
    task automatic load_matrix(input logic [ROW_W-1:0] rx, input logic [ROW_W-1:0] ry,
                               input logic [ROW_W-1:0] rz, input logic [ROW_W-1:0] rw);
        write_row(CFG_ROW_X, rx);
        write_row(CFG_ROW_Y, ry);
        write_row(CFG_ROW_Z, rz);
        write_row(CFG_ROW_W, rw);
        i_cfg_we <= 1'b0;
        matrices_loaded++;
    endtask

    task automatic load_kind(input t_matrix_kind kind);
        logic [ENTRY_W-1:0] w_term;
        case (kind)
            MX_PERSPECTIVE: begin
                // diagonal scale, positive w with a little z coupling
                w_term = ENTRY_W'($urandom_range(32767, 1));
                load_matrix(pack_row(ENTRY_W'($urandom_range(8191, 1024)), 0, 0, 0),
                            pack_row(0, ENTRY_W'($urandom_range(8191, 1024)), 0, 0),
                            pack_row(0, 0, ENTRY_W'($urandom_range(8191, 1024)), 0),
                            pack_row(0, 0, ENTRY_W'(int'($urandom_range(1024)) - 512),
                                     w_term));
            end
            MX_MIRRORED: begin
                // negative diagonal and negative w: the sign of w flips the planes
                w_term = ENTRY_W'(-int'($urandom_range(32767, 1)));
                load_matrix(pack_row(ENTRY_W'(-int'($urandom_range(8191, 1024))), 0, 0, 0),
                            pack_row(0, ENTRY_W'(-int'($urandom_range(8191, 1024))), 0, 0),
                            pack_row(0, 0, ENTRY_W'(-int'($urandom_range(8191, 1024))), 0),
                            pack_row(0, 0, 0, w_term));
            end
            MX_RANDOM:
                load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
            MX_ALL_MAX:
                load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
            MX_ALL_MIN:
                load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
            default:
                load_matrix('0, '0, '0, '0);
        endcase
    endtask

    // eight corners of an axis-aligned box around a random center, or eight
    // unrelated corners when noisy; sizes spread over many magnitudes
    task automatic send_box(input bit noisy);
        int span, ex, ey, ez, mx, my, mz;
        logic signed [CW-1:0] px, py, pz;
        span = 1 << $urandom_range(15, 4);
        if (span > 31000)
            span = 31000;
        mx = int'($urandom_range(2 * span)) - span;
        my = int'($urandom_range(2 * span)) - span;
        mz = int'($urandom_range(2 * span)) - span;
        ex = $urandom_range(1 << $urandom_range(10, 0));
        ey = $urandom_range(1 << $urandom_range(10, 0));
        ez = $urandom_range(1 << $urandom_range(10, 0));
        for (int c = 0; c < CORNERS; c++) begin
            if (noisy) begin
                px = CW'($urandom);
                py = CW'($urandom);
                pz = CW'($urandom);
            end else begin
                px = CW'(((c & 1) != 0) ? mx + ex : mx - ex);
                py = CW'(((c & 2) != 0) ? my + ey : my - ey);
                pz = CW'(((c & 4) != 0) ? mz + ez : mz - ez);
            end
            send_corner(px, py, pz);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero matrix straight out of reset: every corner maps to the origin,
        // nothing is outside, box visible; corners hit the coordinate extremes
        send_corner(16'sh8000, 16'sh8000, 16'sh8000);
        send_corner(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_corner(16'sh0000, 16'sh0000, 16'sh0000);
        send_corner(-16'sd1, -16'sd1, -16'sd1);
        send_corner(16'sh5555, 16'shAAAA, 16'sh5555);
        send_corner(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_corner(16'sh7FFF, 16'sh8000, 16'sd1);
        send_corner(16'sh8000, 16'sd0, 16'sh7FFF);
        settle();

        // identity matrix, w = 1.0: all corners past +x, but sitting exactly on
        // +y and -z, which counts as inside those planes
        load_matrix(pack_row(16'd4096, 0, 0, 0), pack_row(0, 16'd4096, 0, 0),
                    pack_row(0, 0, 16'd4096, 0), pack_row(0, 0, 0, 16'd4096));
        for (int c = 0; c < CORNERS; c++)
            send_corner(CW'(65 + c * 4000), 16'sd64, -16'sd64);

        // matrix change halfway through a box: first half culled on -x under
        // identity, second half on -x under the extreme-entry matrix
        for (int c = 0; c < CORNERS / 2; c++)
            send_corner(CW'(-100 - c * 1000), CW'(c * 20), 16'sd0);
        settle();
        load_matrix(pack_row(16'h8000, 0, 0, 0), pack_row(0, 16'h7FFF, 0, 0),
                    pack_row(0, 0, 16'h8000, 0), pack_row(0, 0, 0, 16'h7FFF));
        for (int c = 0; c < CORNERS / 2; c++)
            send_corner(CW'(32767 - c * 5000), CW'(-c * 20), 16'sd0);
        settle();

        // random phases, each with its own matrix and sender pace
        for (int p = 0; p < RAND_PHASES; p++) begin
            load_kind(PHASE_KIND[p]);
            idle_pct = IDLE_PCT[p % 4];
            for (int b = 0; b < BOXES_PER_PHASE; b++)
                send_box($urandom_range(3) == 0);
            settle();
        end

        $display("tb_top: %0d corner beats, %0d boxes checked, %0d culled",
                 corners_sent, boxes_checked, boxes_culled);
        $display("tb_top: %0d matrix loads incl. zero, all-max, all-min and mid-box change",
                 matrices_loaded);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/csbc_pkg.sv
rtl/csbc_row_dot.sv
rtl/clip_space_box_cull.sv
sim/csbc_checker.sv
sim/tb_top.sv
